// File: src/tbp_pkg.sv
// Shared types, constants and codes for the per-address token bucket policer.
package tbp_pkg;

    localparam int MAX_SOURCES = 256;
    localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
    localparam int ADDR_W      = 64;
    localparam int TIME_W      = 48;
    localparam int TOK_W       = 56;
    localparam int RATE_W      = 40;
    localparam int EXP_W       = 40;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = TIME_W + RATE_W;
    localparam int CHUNK_W     = 16;
    localparam int CHUNKS      = TIME_W / CHUNK_W;
    localparam logic [TOK_W-1:0] ONE_TOKEN   = TOK_W'(64'h1_0000_0000);
    localparam logic [TOK_W-1:0] BURST_RESET = TOK_W'(64'h1_0000_0000);
    localparam logic [EXP_W-1:0] EXPIRY_RESET = EXP_W'(60000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_RATE   = 2'd1,
        CFG_BURST  = 2'd2,
        CFG_EXPIRY = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        V_TAKEN   = 3'd0,
        V_LIMITED = 3'd1,
        V_FULL    = 3'd2,
        V_BYPASS  = 3'd3,
        V_SWEPT   = 3'd4
    } t_verdict;

    typedef enum logic [2:0] {
        CO_NONE   = 3'd0,
        CO_CREATE = 3'd1,
        CO_UPDATE = 3'd2,
        CO_SWEEP  = 3'd3,
        CO_SHIFT  = 3'd4
    } t_cell_op;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic              addr_valid;
        logic [TIME_W-1:0] now_us;
    } t_in_word;

    typedef struct packed {
        logic     allowed;
        t_verdict verdict;
        logic [8:0] entry_count;
    } t_out_word;

    typedef struct packed {
        t_cell_op          op;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [TIME_W-1:0] now_us;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] last_refill;
        logic [EXP_W-1:0]  expiry;
    } t_cell_cmd;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] last_refill;
    } t_cell_stat;

endpackage

// File: src/per_address_token_bucket_policer_top.sv
// Per-address token bucket policer: row of entry cells, refill unit and sequencer.
// One word at a time. The input stays stalled from acceptance until the result is
// loaded. A bypass passes through decide and emit, a new address through decide, alloc
// and emit, a known address through decide, read, write and emit, with the 3-chunk refill
// multiply before write when time has advanced. Any sweep (sweep opcode, or a new address
// on a full table) adds the drain state while the expiry flags shift down the cell chain
// to update the live count. Results wait in an output register; the next word may be
// accepted meanwhile, and a result still stalled there holds the next one in its last state.
module per_address_token_bucket_policer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tbp_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tbp_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tbp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tbp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_DRAIN  = 8'b0000_0100,
        S_ALLOC  = 8'b0000_1000,
        S_READ   = 8'b0001_0000,
        S_MUL    = 8'b0010_0000,
        S_WRITE  = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic              r_enable;
    logic [RATE_W-1:0] r_rate;
    logic [TOK_W-1:0]  r_burst;
    logic [EXP_W-1:0]  r_expiry;

    t_in_word          r_in;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_drain, n_drain;
    logic              r_allowed, n_allowed;
    t_verdict          r_verdict, n_verdict;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out;
    logic              r_mul_start, n_mul_start;
    logic [MAX_SOURCES-1:0] r_sel;
    logic [TOK_W-1:0]  r_tok, r_newtok;
    logic [TIME_W-1:0] r_lr;

    t_cell_cmd         cmd;
    t_cell_stat        stat [MAX_SOURCES];
    logic [MAX_SOURCES:0]   exp_link;
    logic [MAX_SOURCES-1:0] sel_vec;
    logic [MAX_SOURCES-1:0] valid_vec;
    logic [MAX_SOURCES-1:0] hit_vec;
    logic [MAX_SOURCES-1:0] free_vec;
    logic              hit_any;
    logic [TOK_W-1:0]  mux_tok;
    logic [TIME_W-1:0] mux_lr;
    logic              rf_done;
    logic [TOK_W-1:0]  rf_sum;
    logic              full;
    logic              do_refill;

    assign exp_link[0] = 1'b0;

    for (genvar g = 0; g < MAX_SOURCES; g++) begin : g_cell
        tbp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_sel   (sel_vec[g]),
            .i_exp   (exp_link[g]),
            .o_exp   (exp_link[g+1]),
            .o_stat  (stat[g])
        );
        assign valid_vec[g] = stat[g].valid;
        assign hit_vec[g]   = stat[g].hit;
    end

    always_comb begin
        mux_tok = '0;
        mux_lr  = '0;
        for (int k = 0; k < MAX_SOURCES; k++) begin
            mux_tok = mux_tok | (hit_vec[k] ? stat[k].tokens : '0);
            mux_lr  = mux_lr  | (hit_vec[k] ? stat[k].last_refill : '0);
        end
    end

    assign hit_any   = |hit_vec;
    assign free_vec  = ~valid_vec & (valid_vec + MAX_SOURCES'(1));
    assign full      = (r_count >= CNT_W'(MAX_SOURCES));
    assign do_refill = (r_in.now_us > r_lr);

    tbp_refill u_refill (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_elapsed (r_in.now_us - r_lr),
        .i_rate    (r_rate),
        .i_tokens  (r_tok),
        .i_burst   (r_burst),
        .o_done    (rf_done),
        .o_sum     (rf_sum)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drain     = r_drain;
        n_allowed   = r_allowed;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid;
        n_mul_start = 1'b0;
        cmd.op          = CO_NONE;
        cmd.addr_high   = r_in.addr_high;
        cmd.addr_low    = r_in.addr_low;
        cmd.now_us      = r_in.now_us;
        cmd.tokens      = r_newtok;
        cmd.last_refill = do_refill ? r_in.now_us : r_lr;
        cmd.expiry      = r_expiry;
        sel_vec         = '0;

        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_in.opcode) begin
                    cmd.op  = CO_SWEEP;
                    n_drain = CNT_W'(MAX_SOURCES - 1);
                    n_state = S_DRAIN;
                end else if (!r_enable || !r_in.addr_valid) begin
                    n_allowed = 1'b1;
                    n_verdict = V_BYPASS;
                    n_state   = S_EMIT;
                end else if (hit_any) begin
                    n_state = S_READ;
                end else if (full) begin
                    cmd.op  = CO_SWEEP;
                    n_drain = CNT_W'(MAX_SOURCES - 1);
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_DRAIN: begin
                cmd.op = CO_SHIFT;
                if (exp_link[MAX_SOURCES] && r_count != '0) n_count = r_count - 1'b1;
                n_drain = r_drain - 1'b1;
                if (r_drain == '0) begin
                    if (r_in.opcode) begin
                        n_allowed = 1'b0;
                        n_verdict = V_SWEPT;
                        n_state   = S_EMIT;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                if (!full) begin
                    cmd.op      = CO_CREATE;
                    sel_vec     = free_vec;
                    n_count     = r_count + 1'b1;
                    cmd.tokens  = (r_burst >= ONE_TOKEN) ? r_burst - ONE_TOKEN : r_burst;
                    n_allowed   = (r_burst >= ONE_TOKEN);
                    n_verdict   = (r_burst >= ONE_TOKEN) ? V_TAKEN : V_LIMITED;
                end else begin
                    n_allowed = 1'b0;
                    n_verdict = V_FULL;
                end
                n_state = S_EMIT;
            end
            S_READ: begin
                if (r_in.now_us > mux_lr) begin
                    n_mul_start = 1'b1;
                    n_state     = S_MUL;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_MUL: begin
                if (rf_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                cmd.op     = CO_UPDATE;
                sel_vec    = r_sel;
                cmd.tokens = (r_newtok >= ONE_TOKEN) ? r_newtok - ONE_TOKEN : r_newtok;
                n_allowed  = (r_newtok >= ONE_TOKEN);
                n_verdict  = (r_newtok >= ONE_TOKEN) ? V_TAKEN : V_LIMITED;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
            r_mul_start <= 1'b0;
            r_allowed   <= 1'b0;
            r_verdict   <= V_BYPASS;
            r_enable    <= 1'b0;
            r_rate      <= '0;
            r_burst     <= BURST_RESET;
            r_expiry    <= EXPIRY_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
            r_mul_start <= n_mul_start;
            r_allowed   <= n_allowed;
            r_verdict   <= n_verdict;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    CFG_RATE:   r_rate   <= i_cfg_data[RATE_W-1:0];
                    CFG_BURST:  r_burst  <= i_cfg_data[TOK_W-1:0];
                    CFG_EXPIRY: r_expiry <= i_cfg_data[EXP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) r_in <= i_in_word;
        if (r_state == S_READ) begin
            r_sel    <= hit_vec;
            r_tok    <= mux_tok;
            r_lr     <= mux_lr;
            r_newtok <= mux_tok;
        end
        if (r_state == S_MUL && rf_done) r_newtok <= rf_sum;
        if (r_state == S_EMIT && (!r_out_valid || !i_out_stall)) begin
            r_out.allowed     <= r_allowed;
            r_out.verdict     <= r_verdict;
            r_out.entry_count <= 9'(r_count);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SOURCES)) else $error("live count above table size");
    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec)) else $error("address held in two entries");
    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_done |-> r_state == S_MUL) else $error("refill done outside multiply");
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC && !full) |=> r_count == $past(r_count) + 1'b1)
        else $error("new entry not counted");
`endif

endmodule

// File: src/tbp_cell.sv
// One table entry: address match, expiry test and a link of the expiry drain chain.
module tbp_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbp_pkg::t_cell_cmd i_cmd,
    input  logic               i_sel,
    input  logic               i_exp,
    output logic               o_exp,
    output tbp_pkg::t_cell_stat o_stat
);
    import tbp_pkg::*;

    logic              r_valid;
    logic              r_exp;
    logic [ADDR_W-1:0] r_addr_high;
    logic [ADDR_W-1:0] r_addr_low;
    logic [TOK_W-1:0]  r_tokens;
    logic [TIME_W-1:0] r_last_refill;
    logic [TIME_W-1:0] r_last_seen;
    logic [TIME_W-1:0] idle;
    logic              expire;

    assign idle   = i_cmd.now_us - r_last_seen;
    assign expire = r_valid && (i_cmd.now_us >= r_last_seen) &&
                    (idle > {{(TIME_W-EXP_W){1'b0}}, i_cmd.expiry});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_exp   <= 1'b0;
        end else begin
            case (i_cmd.op)
                CO_CREATE: if (i_sel) r_valid <= 1'b1;
                CO_SWEEP: begin
                    r_exp <= expire;
                    if (expire) r_valid <= 1'b0;
                end
                CO_SHIFT: r_exp <= i_exp;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel && i_cmd.op == CO_CREATE) begin
            r_addr_high   <= i_cmd.addr_high;
            r_addr_low    <= i_cmd.addr_low;
            r_tokens      <= i_cmd.tokens;
            r_last_refill <= i_cmd.now_us;
            r_last_seen   <= i_cmd.now_us;
        end else if (i_sel && i_cmd.op == CO_UPDATE) begin
            r_tokens      <= i_cmd.tokens;
            r_last_refill <= i_cmd.last_refill;
            r_last_seen   <= i_cmd.now_us;
        end
    end

    assign o_exp              = r_exp;
    assign o_stat.valid       = r_valid;
    assign o_stat.hit         = r_valid && (r_addr_high == i_cmd.addr_high) &&
                                (r_addr_low == i_cmd.addr_low);
    assign o_stat.tokens      = r_tokens;
    assign o_stat.last_refill = r_last_refill;

endmodule

// File: src/tbp_refill.sv
// Iterative refill: elapsed times rate in 16-bit chunks, then saturating add and burst cap.
module tbp_refill (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tbp_pkg::TIME_W-1:0] i_elapsed,
    input  logic [tbp_pkg::RATE_W-1:0] i_rate,
    input  logic [tbp_pkg::TOK_W-1:0]  i_tokens,
    input  logic [tbp_pkg::TOK_W-1:0]  i_burst,
    output logic                       o_done,
    output logic [tbp_pkg::TOK_W-1:0]  o_sum
);
    import tbp_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [1:0]          r_step;
    logic [TIME_W-1:0]   r_el;
    logic [PROD_W-1:0]   r_acc;
    logic [TOK_W-1:0]    r_sum;
    logic [CHUNK_W+RATE_W-1:0] part;
    logic [64:0]         s65;
    logic                over;

    assign part = r_el[TIME_W-1 -: CHUNK_W] * i_rate;
    assign s65  = {9'd0, i_tokens} + {1'b0, r_acc[63:0]};
    assign over = (|r_acc[PROD_W-1:64]) || s65[64] ||
                  (s65[63:0] > {8'd0, i_burst});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 2'(CHUNKS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_el  <= i_elapsed;
            r_acc <= '0;
        end else if (r_busy && r_step != 2'(CHUNKS)) begin
            r_el  <= r_el << CHUNK_W;
            r_acc <= (r_acc << CHUNK_W) + PROD_W'(part);
        end else if (r_busy) begin
            r_sum <= over ? i_burst : s65[TOK_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule
